// ----- hdl/hpq_pkg.sv -----
package hpq_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 10;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] min;
    logic        [CNT_W-1:0]  count;
    logic        [1:0]        status;
  } res_t;

endpackage

// ----- hdl/min_heap_priority_queue.sv -----
// Binary min-heap of signed 32-bit keys. Issue a command by raising start while busy is low:
// insert, pop minimum or clear. Each command yields exactly one result beat, held on the out_
// ports for one cycle with out_valid high; the receiver cannot stall it. After the accepting
// cycle an insert keeps busy high while the key climbs, reading and comparing one parent per
// level; a pop of more than one entry keeps it high while the last entry is read and sifted
// down, reading and comparing the children of each level. The pace is set by the heap memory,
// which has registered read data and is not read and written in the same cycle, and by the
// one shared key comparator. Clear, overflow, underflow and a pop that empties the heap keep
// busy high for 1 cycle. The result beat is on the out_ ports in the first cycle that busy is
// low again, and the next command may be issued in that same cycle. The heap is full at
// DEPTH-1 entries.
module min_heap_priority_queue #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_command,
  input  logic signed [hpq_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic signed [hpq_pkg::DATA_W-1:0] out_popped_value,
  output logic signed [hpq_pkg::DATA_W-1:0] out_min_value,
  output logic [hpq_pkg::CNT_W-1:0]         out_entry_count,
  output logic [1:0]                        out_status
);

  localparam int AW = $clog2(DEPTH);

  logic                              mem_we, mem_re;
  logic [AW-1:0]                     mem_waddr, mem_raddr;
  logic signed [hpq_pkg::DATA_W-1:0] mem_wdata;
  logic signed [hpq_pkg::DATA_W-1:0] mem_rdata_r;
  logic signed [hpq_pkg::DATA_W-1:0] heap_mem [DEPTH];
  hpq_pkg::res_t                     res;

  logic                              out_valid_r;
  logic signed [hpq_pkg::DATA_W-1:0] out_popped_r, out_min_r;
  logic [hpq_pkg::CNT_W-1:0]         out_count_r;
  logic [1:0]                        out_status_r;

  hpq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .cmd      (in_command),
    .value    (in_value),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata_r),
    .res      (res)
  );

  // heap store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= heap_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_popped_r <= res.popped;
      out_min_r    <= res.min;
      out_count_r  <= res.count;
      out_status_r <= res.status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_min_value    = out_min_r;
  assign out_entry_count  = out_count_r;
  assign out_status       = out_status_r;

endmodule

// ----- hdl/hpq_ctrl.sv -----
module hpq_ctrl #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       cmd,
  input  logic signed [hpq_pkg::DATA_W-1:0] value,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic signed [hpq_pkg::DATA_W-1:0] mem_wdata,
  output logic                             mem_re,
  output logic [AW-1:0]                    mem_raddr,
  input  logic signed [hpq_pkg::DATA_W-1:0] mem_rdata,
  output hpq_pkg::res_t                    res
);

  localparam int CW = hpq_pkg::CNT_W;
  localparam logic [AW-1:0] FULL_CNT = AW'(DEPTH - 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP_CHK  = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_DN_LAST = 9'b000001000,
    S_DN_CHK  = 9'b000010000,
    S_DN_RDR  = 9'b000100000,
    S_DN_CMP  = 9'b001000000,
    S_DN_SWP  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic signed [hpq_pkg::DATA_W-1:0] key_r, key_nxt;
  logic signed [hpq_pkg::DATA_W-1:0] lv_r, lv_nxt;
  logic signed [hpq_pkg::DATA_W-1:0] root_r, root_nxt;
  logic signed [hpq_pkg::DATA_W-1:0] popped_r, popped_nxt;
  logic [1:0] status_r, status_nxt;

  logic signed [hpq_pkg::DATA_W-1:0] cmp_a, cmp_b;
  logic lt;
  logic [AW:0] left_w, right_w, cnt_ext;
  logic [AW-1:0] parent;

  // shared signed compare unit
  always_comb begin
    case (state_r)
      S_UP_CMP: begin
        cmp_a = key_r;
        cmp_b = mem_rdata;
      end
      S_DN_CMP: begin
        cmp_a = mem_rdata;
        cmp_b = lv_r;
      end
      default: begin
        cmp_a = lv_r;
        cmp_b = key_r;
      end
    endcase
  end
  assign lt = cmp_a < cmp_b;

  assign left_w  = {pos_r, 1'b1};
  assign right_w = left_w + (AW+1)'(1);
  assign cnt_ext = {1'b0, cnt_r};
  assign parent  = (pos_r - AW'(1)) >> 1;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    best_nxt   = best_r;
    key_nxt    = key_r;
    lv_nxt     = lv_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = pos_r;
    mem_wdata  = key_r;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          popped_nxt = '0;
          status_nxt = hpq_pkg::ST_OK;
          state_nxt  = S_DONE;
          case (cmd)
            hpq_pkg::CMD_INSERT: begin
              if (cnt_r >= FULL_CNT) begin
                status_nxt = hpq_pkg::ST_OVERFLOW;
              end else begin
                pos_nxt   = cnt_r;
                key_nxt   = value;
                cnt_nxt   = cnt_r + AW'(1);
                state_nxt = S_UP_CHK;
              end
            end
            hpq_pkg::CMD_POP: begin
              if (cnt_r == '0) begin
                status_nxt = hpq_pkg::ST_UNDERFLOW;
              end else begin
                popped_nxt = root_r;
                cnt_nxt    = cnt_r - AW'(1);
                if (cnt_r != AW'(1)) begin
                  mem_re    = 1'b1;
                  mem_raddr = cnt_r - AW'(1);
                  state_nxt = S_DN_LAST;
                end
              end
            end
            hpq_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              cnt_nxt = cnt_r;
            end
          endcase
        end
      end
      S_UP_CHK: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent;
          best_nxt  = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (lt) begin
          mem_wdata = mem_rdata;
          pos_nxt   = best_r;
          state_nxt = S_UP_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN_LAST: begin
        key_nxt   = mem_rdata;
        pos_nxt   = '0;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (left_w >= cnt_ext) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = left_w[AW-1:0];
          state_nxt = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        lv_nxt   = mem_rdata;
        best_nxt = left_w[AW-1:0];
        if (right_w < cnt_ext) begin
          mem_re    = 1'b1;
          mem_raddr = right_w[AW-1:0];
          state_nxt = S_DN_CMP;
        end else begin
          state_nxt = S_DN_SWP;
        end
      end
      S_DN_CMP: begin
        if (lt) begin
          lv_nxt   = mem_rdata;
          best_nxt = right_w[AW-1:0];
        end
        state_nxt = S_DN_SWP;
      end
      S_DN_SWP: begin
        mem_we = 1'b1;
        if (lt) begin
          mem_wdata = lv_r;
          pos_nxt   = best_r;
          state_nxt = S_DN_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // cached root tracks every write to the top slot
  always_comb begin
    root_nxt = root_r;
    if (mem_we && mem_waddr == '0) begin
      root_nxt = mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    best_r   <= best_nxt;
    key_r    <= key_nxt;
    lv_r     <= lv_nxt;
    root_r   <= root_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    res.valid  = (state_r == S_DONE);
    res.popped = popped_r;
    res.min    = (cnt_r != '0) ? root_r : '0;
    res.count  = CW'(cnt_r);
    res.status = status_r;
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 1024;
  localparam int IDLE_LIMIT = 1000;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic signed [hpq_pkg::DATA_W-1:0] KEY_MAX = 32'sh7fffffff;
  localparam logic signed [hpq_pkg::DATA_W-1:0] KEY_MIN = 32'sh80000000;
  localparam logic signed [hpq_pkg::DATA_W-1:0] KEY_NEG1 = 32'shffffffff;
  localparam logic signed [hpq_pkg::DATA_W-1:0] KEY_ZERO = 32'sh0;

  typedef struct packed {
    logic signed [hpq_pkg::DATA_W-1:0] popped;
    logic signed [hpq_pkg::DATA_W-1:0] min_key;
    logic        [hpq_pkg::CNT_W-1:0]  count;
    logic        [1:0]                 status;
  } heap_result_t;

  typedef struct packed {
    logic        [1:0]                 cmd;
    logic signed [hpq_pkg::DATA_W-1:0] key;
    logic                              typed;
    logic signed [hpq_pkg::DATA_W-1:0] popped;
    logic signed [hpq_pkg::DATA_W-1:0] min_key;
    logic        [hpq_pkg::CNT_W-1:0]  count;
    logic        [1:0]                 status;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [1:0]                        in_command;
  logic signed [hpq_pkg::DATA_W-1:0] in_value;
  logic                              out_valid;
  logic signed [hpq_pkg::DATA_W-1:0] out_popped_value;
  logic signed [hpq_pkg::DATA_W-1:0] out_min_value;
  logic [hpq_pkg::CNT_W-1:0]         out_entry_count;
  logic [1:0]                        out_status;

  logic signed [hpq_pkg::DATA_W-1:0] shadow_keys [DEPTH];
  int unsigned                       shadow_fill = 0;
  heap_result_t                      pending_results [$];
  heap_result_t                      oldest_result;
  stim_row_t                         directed_rows [$];
  int                                mismatch_count = 0;
  int                                idle_cycles = 0;
  int                                quiet_left = 0;

  min_heap_priority_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_min_value    (out_min_value),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic heap_result_t apply_heap_command(
      input logic [1:0] cmd, input logic signed [hpq_pkg::DATA_W-1:0] key);
    heap_result_t                      r;
    int unsigned                       pos;
    int unsigned                       parent;
    int unsigned                       kid_l;
    int unsigned                       kid_r;
    int unsigned                       best;
    logic signed [hpq_pkg::DATA_W-1:0] t;
    r.popped = '0;
    r.status = hpq_pkg::ST_OK;
    if (cmd == hpq_pkg::CMD_INSERT) begin
      if (shadow_fill >= DEPTH - 1) begin
        r.status = hpq_pkg::ST_OVERFLOW;
      end else begin
        pos = shadow_fill;
        shadow_keys[pos] = key;
        shadow_fill = pos + 1;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (shadow_keys[pos] < shadow_keys[parent]) begin
            t = shadow_keys[pos];
            shadow_keys[pos] = shadow_keys[parent];
            shadow_keys[parent] = t;
            pos = parent;
          end else begin
            break;
          end
        end
      end
    end else if (cmd == hpq_pkg::CMD_POP) begin
      if (shadow_fill == 0) begin
        r.status = hpq_pkg::ST_UNDERFLOW;
      end else begin
        r.popped = shadow_keys[0];
        shadow_fill = shadow_fill - 1;
        shadow_keys[0] = shadow_keys[shadow_fill];
        pos = 0;
        forever begin
          kid_l = 2 * pos + 1;
          kid_r = 2 * pos + 2;
          best = pos;
          if (kid_l < shadow_fill && shadow_keys[kid_l] < shadow_keys[best]) best = kid_l;
          if (kid_r < shadow_fill && shadow_keys[kid_r] < shadow_keys[best]) best = kid_r;
          if (best == pos) break;
          t = shadow_keys[pos];
          shadow_keys[pos] = shadow_keys[best];
          shadow_keys[best] = t;
          pos = best;
        end
      end
    end else if (cmd == hpq_pkg::CMD_CLEAR) begin
      shadow_fill = 0;
    end
    r.min_key = (shadow_fill > 0) ? shadow_keys[0] : KEY_ZERO;
    r.count = shadow_fill[hpq_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [hpq_pkg::DATA_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return KEY_MAX;
      1: return KEY_MIN;
      2, 3: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd,
                           input logic signed [hpq_pkg::DATA_W-1:0] key,
                           input logic typed, input heap_result_t want);
    int           gap;
    heap_result_t predicted;
    gap = (quiet_left > 0) ? 0 : $urandom_range(0, 7);
    if (quiet_left > 0) begin
      quiet_left--;
    end else if ($urandom_range(0, 31) == 0) begin
      quiet_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_value <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_heap_command(cmd, key);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // one result beat per accepted command, checked in order
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat at %0t", $time);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_popped_value !== oldest_result.popped ||
            out_min_value !== oldest_result.min_key ||
            out_entry_count !== oldest_result.count ||
            out_status !== oldest_result.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: exp popped %0d min %0d count %0d status %0d, got %0d %0d %0d %0d",
                     $time, oldest_result.popped, oldest_result.min_key, oldest_result.count,
                     oldest_result.status, out_popped_value, out_min_value, out_entry_count,
                     out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int         roll;
    int         size_goal;
    logic [1:0] cmd;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_command <= hpq_pkg::CMD_INSERT;
    in_value <= KEY_ZERO;
    size_goal = 0;

    directed_rows.push_back({hpq_pkg::CMD_POP, KEY_ZERO, 1'b1, KEY_ZERO, KEY_ZERO, 10'd0,
                             hpq_pkg::ST_UNDERFLOW});
    directed_rows.push_back({hpq_pkg::CMD_CLEAR, KEY_ZERO, 1'b1, KEY_ZERO, KEY_ZERO, 10'd0,
                             hpq_pkg::ST_OK});
    directed_rows.push_back({CMD_NOP, KEY_ZERO, 1'b1, KEY_ZERO, KEY_ZERO, 10'd0,
                             hpq_pkg::ST_OK});
    directed_rows.push_back({hpq_pkg::CMD_INSERT, KEY_MAX, 1'b1, KEY_ZERO, KEY_MAX, 10'd1,
                             hpq_pkg::ST_OK});
    directed_rows.push_back({hpq_pkg::CMD_INSERT, KEY_MIN, 1'b1, KEY_ZERO, KEY_MIN, 10'd2,
                             hpq_pkg::ST_OK});
    directed_rows.push_back({hpq_pkg::CMD_INSERT, KEY_ZERO, 1'b1, KEY_ZERO, KEY_MIN, 10'd3,
                             hpq_pkg::ST_OK});
    directed_rows.push_back({hpq_pkg::CMD_INSERT, KEY_NEG1, 1'b1, KEY_ZERO, KEY_MIN, 10'd4,
                             hpq_pkg::ST_OK});
    directed_rows.push_back({CMD_NOP, 32'sh5a5a5a5a, 1'b1, KEY_ZERO, KEY_MIN, 10'd4,
                             hpq_pkg::ST_OK});
    directed_rows.push_back({hpq_pkg::CMD_POP, KEY_ZERO, 1'b1, KEY_MIN, KEY_NEG1, 10'd3,
                             hpq_pkg::ST_OK});
    directed_rows.push_back({hpq_pkg::CMD_INSERT, 32'sd5, 1'b0, 76'd0});
    directed_rows.push_back({hpq_pkg::CMD_INSERT, 32'sd5, 1'b0, 76'd0});
    directed_rows.push_back({hpq_pkg::CMD_INSERT, 32'sd5, 1'b0, 76'd0});
    directed_rows.push_back({hpq_pkg::CMD_INSERT, KEY_NEG1, 1'b0, 76'd0});
    repeat (7) directed_rows.push_back({hpq_pkg::CMD_POP, KEY_MAX, 1'b0, 76'd0});
    directed_rows.push_back({hpq_pkg::CMD_POP, KEY_NEG1, 1'b1, KEY_ZERO, KEY_ZERO, 10'd0,
                             hpq_pkg::ST_UNDERFLOW});
    directed_rows.push_back({hpq_pkg::CMD_INSERT, 32'sd3, 1'b0, 76'd0});
    directed_rows.push_back({hpq_pkg::CMD_CLEAR, KEY_NEG1, 1'b1, KEY_ZERO, KEY_ZERO, 10'd0,
                             hpq_pkg::ST_OK});
    directed_rows.push_back({hpq_pkg::CMD_POP, KEY_ZERO, 1'b1, KEY_ZERO, KEY_ZERO, 10'd0,
                             hpq_pkg::ST_UNDERFLOW});
    directed_rows.push_back({hpq_pkg::CMD_INSERT, 32'sh55555555, 1'b0, 76'd0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].typed,
                {directed_rows[i].popped, directed_rows[i].min_key, directed_rows[i].count,
                 directed_rows[i].status});

    // heap size wanders around a moving target
    for (int n = 0; n < 470; n++) begin
      if (n % 40 == 0)
        size_goal = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
      roll = $urandom_range(0, 99);
      if (roll < 2) cmd = hpq_pkg::CMD_CLEAR;
      else if (roll < 4) cmd = CMD_NOP;
      else if ((shadow_fill < size_goal) == (roll < 76)) cmd = hpq_pkg::CMD_INSERT;
      else cmd = hpq_pkg::CMD_POP;
      send_item(cmd, (cmd == hpq_pkg::CMD_INSERT) ? pick_key() : $urandom, 1'b0, '0);
    end

    // empty the heap and pop once more
    send_item(hpq_pkg::CMD_CLEAR, $urandom, 1'b0, '0);
    send_item(hpq_pkg::CMD_POP, $urandom, 1'b0, '0);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
